/* sv/pbah_pkg.sv */
// shared types and constants for the per-board adc histogram
package pbah_pkg;

  localparam int NUM_BOARDS_DEF = 8;
  localparam int ADC_BITS_DEF   = 12;
  localparam int COUNT_BITS_DEF = 32;

  localparam int BOARD_W     = 3;
  localparam int CODE_W      = 12;
  localparam int BIN_COUNT_W = 32;

  localparam int QUEUE_DEPTH = 4;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [BOARD_W-1:0] board;
    logic [CODE_W-1:0]  adc_code;
  } in_item_t;

  typedef struct packed {
    logic [BIN_COUNT_W-1:0] bin_count;
    logic                   was_filled;
    logic                   board_used;
  } out_item_t;

  // classified command passed from the front end to the histogram engine
  typedef struct packed {
    logic               is_read;
    logic               bd_ok;
    logic               code_ok;
    logic [BOARD_W-1:0] board;
    logic [CODE_W-1:0]  adc_code;
  } cmd_t;

endpackage

/* sv/per_board_adc_histogram.sv */
// a read's result passes through the command queue, the s1 register and the result register; an output stall holds it
// throughput: one item per cycle while in_ready is high; records and reads share one bin read-modify-write stage
// a 4-entry command queue sits between input checks and the bin memory
// reset: synchronous, active low; then a clearing pass zeroes all NUM_BOARDS * 2**ADC_BITS bins
// (32768 at the defaults), with in_ready low until it ends
module per_board_adc_histogram #(
  parameter int NUM_BOARDS = pbah_pkg::NUM_BOARDS_DEF,
  parameter int ADC_BITS   = pbah_pkg::ADC_BITS_DEF,
  parameter int COUNT_BITS = pbah_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pbah_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output pbah_pkg::out_item_t out_item
);
  import pbah_pkg::*;

  logic busy;
  logic q_vld;
  logic q_pop;
  cmd_t q_cmd;

  pbah_front #(
    .NUM_BOARDS(NUM_BOARDS),
    .ADC_BITS  (ADC_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item (in_item),
    .busy    (busy),
    .q_vld   (q_vld),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  pbah_engine #(
    .NUM_BOARDS(NUM_BOARDS),
    .ADC_BITS  (ADC_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .busy     (busy),
    .q_vld    (q_vld),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

/* sv/pbah_front.sv */
// input front end: range checks, drops ignored records, small command queue
module pbah_front #(
  parameter int NUM_BOARDS = pbah_pkg::NUM_BOARDS_DEF,
  parameter int ADC_BITS   = pbah_pkg::ADC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pbah_pkg::in_item_t in_item,
  input  logic              busy,
  output logic              q_vld,
  output pbah_pkg::cmd_t    q_cmd,
  input  logic              q_pop
);
  import pbah_pkg::*;

  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_t           q_mem_r [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  cmd_t cmd;
  logic push;
  logic full;

  always_comb begin
    cmd.is_read  = (in_item.operation == OP_READ);
    cmd.bd_ok    = 32'(in_item.board) < 32'(NUM_BOARDS);
    cmd.code_ok  = (32'(in_item.adc_code) >> ADC_BITS) == 32'd0;
    cmd.board    = in_item.board;
    cmd.adc_code = in_item.adc_code;
  end

  assign full     = (cnt_r == QCW'(QUEUE_DEPTH));
  assign in_ready = !full && !busy;
  // records that fall outside the histogram change nothing and are dropped here
  assign push     = in_valid && in_ready && (cmd.is_read || (cmd.bd_ok && cmd.code_ok));
  assign q_vld    = (cnt_r != '0);
  assign q_cmd    = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + QPW'(1);
    end
    if (q_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + QPW'(1);
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= QUEUE_DEPTH)
    else $error("command queue count exceeds depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != '0)
    else $error("pop from empty command queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full command queue");

endmodule

/* sv/pbah_engine.sv */
// histogram engine: bin memory with clearing pass, read-modify-write, result register
module pbah_engine #(
  parameter int NUM_BOARDS = pbah_pkg::NUM_BOARDS_DEF,
  parameter int ADC_BITS   = pbah_pkg::ADC_BITS_DEF,
  parameter int COUNT_BITS = pbah_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  output logic               busy,
  input  logic               q_vld,
  input  pbah_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output pbah_pkg::out_item_t out_item
);
  import pbah_pkg::*;

  localparam int BW        = (NUM_BOARDS > 1) ? $clog2(NUM_BOARDS) : 1;
  localparam int AW        = BW + ADC_BITS;
  localparam int MEM_DEPTH = NUM_BOARDS << ADC_BITS;

  logic [COUNT_BITS-1:0] mem [MEM_DEPTH];

  logic                  clr_busy_r, clr_busy_nxt;
  logic [AW-1:0]         clr_addr_r, clr_addr_nxt;

  logic                  s1_vld_r, s1_vld_nxt;
  cmd_t                  s1_r;
  logic [COUNT_BITS-1:0] rd_data_r;
  logic                  fwd_hit_r;
  logic [COUNT_BITS-1:0] fwd_data_r;

  logic [NUM_BOARDS-1:0] used_r, used_nxt;
  logic [NUM_BOARDS-1:0] seen_r, seen_nxt;

  logic                  out_vld_r, out_vld_nxt;
  out_item_t             out_item_r, out_item_nxt;

  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         s1_addr;
  logic [BW-1:0]         s1_bidx;
  logic [ADC_BITS-1:0]   s1_cidx;
  logic                  s2_stall;
  logic                  s2_go;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic [COUNT_BITS-1:0] rep_cnt;
  logic                  seen_tmp;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  assign rd_addr  = {BW'(q_cmd.board), ADC_BITS'(q_cmd.adc_code)};
  assign s1_bidx  = BW'(s1_r.board);
  assign s1_cidx  = ADC_BITS'(s1_r.adc_code);
  assign s1_addr  = {s1_bidx, s1_cidx};

  // only a read waits on the result register, so a stalled stage never writes
  assign s2_stall = s1_vld_r && s1_r.is_read && out_vld_r && !out_ready;
  assign s2_go    = s1_vld_r && !s2_stall;
  assign q_pop    = q_vld && !s2_stall && !clr_busy_r;
  assign busy     = clr_busy_r;
  assign cur_cnt  = fwd_hit_r ? fwd_data_r : rd_data_r;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (32'(clr_addr_r) == MEM_DEPTH - 1) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    s1_vld_nxt   = s1_vld_r;
    used_nxt     = used_r;
    seen_nxt     = seen_r;
    out_vld_nxt  = out_vld_r;
    out_item_nxt = out_item_r;
    rep_cnt      = cur_cnt;
    seen_tmp     = 1'b0;
    wr_en        = clr_busy_r;
    wr_addr      = clr_addr_r;
    wr_data      = '0;

    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (q_pop) begin
      s1_vld_nxt = 1'b1;
    end else if (!s2_stall) begin
      s1_vld_nxt = 1'b0;
    end

    if (s2_go) begin
      if (!s1_r.is_read) begin
        wr_en    = 1'b1;
        wr_addr  = s1_addr;
        // saturate at all ones
        wr_data  = (cur_cnt == '1) ? cur_cnt : cur_cnt + COUNT_BITS'(1);
        used_nxt[s1_bidx] = 1'b1;
      end else begin
        out_vld_nxt             = 1'b1;
        out_item_nxt.bin_count  = '0;
        out_item_nxt.was_filled = 1'b0;
        out_item_nxt.board_used = 1'b0;
        if (s1_r.bd_ok) begin
          out_item_nxt.board_used = used_r[s1_bidx];
          if (s1_r.code_ok) begin
            // top code restarts the fill rule for this board
            seen_tmp = (s1_cidx == '1) ? 1'b0 : seen_r[s1_bidx];
            if (cur_cnt != '0) begin
              seen_tmp = 1'b1;
            end
            if (cur_cnt == '0 && seen_tmp) begin
              rep_cnt                 = COUNT_BITS'(1);
              out_item_nxt.was_filled = 1'b1;
            end
            seen_nxt[s1_bidx]      = seen_tmp;
            out_item_nxt.bin_count = BIN_COUNT_W'(rep_cnt);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      s1_vld_r   <= 1'b0;
      used_r     <= '0;
      seen_r     <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
      s1_vld_r   <= s1_vld_nxt;
      used_r     <= used_nxt;
      seen_r     <= seen_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (q_pop) begin
      s1_r       <= q_cmd;
      // catch the write landing at the same edge as this read
      fwd_hit_r  <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (q_pop) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  a_no_work_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !s1_vld_r && !q_pop)
    else $error("command taken during clearing pass");

  a_record_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !s1_r.is_read |-> s1_r.bd_ok && s1_r.code_ok)
    else $error("out-of-range record reached the bin memory");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ready |=> out_vld_r && $stable(out_item_r))
    else $error("result beat changed while waiting");

endmodule

/* test/per_board_adc_histogram_test.sv */
// self-checking testbench for the per-board adc histogram: directed and random beats
`timescale 1ns / 100ps

module per_board_adc_histogram_test;
  import pbah_pkg::*;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          TAIL_CYCLES = 20;
  localparam int          BIN_DEPTH   = 1 << CODE_W;
  localparam int unsigned CODE_TOP    = BIN_DEPTH - 1;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // histogram shadow state
  bit [BIN_COUNT_W-1:0] hist_bins [NUM_BOARDS_DEF][BIN_DEPTH];
  bit                   seen_flag [NUM_BOARDS_DEF];
  bit                   used_flag [NUM_BOARDS_DEF];

  in_item_t  stim_beats[$];
  out_item_t expected_bins[$];

  int unsigned cycle_cnt = 0;
  int unsigned beats_taken = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          idle_phase = 1'b0;

  per_board_adc_histogram u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // apply one accepted beat to the shadow histogram; reads queue their result
  task automatic histogram_update(input in_item_t beat);
    out_item_t            res;
    bit [BIN_COUNT_W-1:0] cnt;
    begin
      if (beat.operation == OP_RECORD) begin
        if (hist_bins[beat.board][beat.adc_code] != '1)
          hist_bins[beat.board][beat.adc_code]++;
        used_flag[beat.board] = 1'b1;
      end else begin
        res = '0;
        res.board_used = used_flag[beat.board];
        cnt = hist_bins[beat.board][beat.adc_code];
        if (32'(beat.adc_code) == CODE_TOP)
          seen_flag[beat.board] = 1'b0;
        if (cnt != 0)
          seen_flag[beat.board] = 1'b1;
        // zero bin below a nonzero one in the downward sweep
        if (cnt == 0 && seen_flag[beat.board]) begin
          cnt = 1;
          res.was_filled = 1'b1;
        end
        res.bin_count = cnt;
        expected_bins.push_back(res);
      end
    end
  endtask

  task automatic add_beat(input logic op, input int unsigned bd, input int unsigned code);
    in_item_t beat;
    begin
      beat.operation = op;
      beat.board     = bd[BOARD_W-1:0];
      beat.adc_code  = code[CODE_W-1:0];
      stim_beats.push_back(beat);
    end
  endtask

  // stimulus
  initial begin
    int unsigned bd;
    int unsigned code;
    int unsigned len;
    int unsigned pick;

    add_beat(OP_READ, 0, CODE_TOP);
    add_beat(OP_READ, 0, 100);
    add_beat(OP_RECORD, 0, 0);
    add_beat(OP_RECORD, 7, CODE_TOP);
    add_beat(OP_RECORD, 7, CODE_TOP);
    add_beat(OP_RECORD, 5, 'haaa);
    add_beat(OP_RECORD, 2, 'h555);
    add_beat(OP_READ, 7, CODE_TOP);
    add_beat(OP_READ, 7, CODE_TOP - 1);
    add_beat(OP_READ, 7, 0);
    add_beat(OP_READ, 0, CODE_TOP);
    add_beat(OP_READ, 0, 1);
    add_beat(OP_READ, 0, 0);
    add_beat(OP_READ, 0, CODE_TOP);
    add_beat(OP_READ, 0, 2048);
    add_beat(OP_READ, 5, 'haaa);
    add_beat(OP_READ, 5, 'haa9);
    add_beat(OP_READ, 2, 'h555);
    add_beat(OP_READ, 3, CODE_TOP);
    add_beat(OP_READ, 3, 0);
    add_beat(OP_READ, 7, CODE_TOP);
    add_beat(OP_READ, 2, CODE_TOP);
    add_beat(OP_READ, 2, 'h554);

    while (stim_beats.size() < 1970) begin
      pick = $urandom_range(0, 9);
      bd   = $urandom_range(0, NUM_BOARDS_DEF - 1);
      if (pick <= 3) begin
        // fill the upper bins so that downward sweeps meet nonzero counts
        len = $urandom_range(3, 20);
        repeat (len) begin
          if ($urandom_range(0, 4) == 0)
            code = $urandom_range(0, BIN_DEPTH - 1);
          else
            code = CODE_TOP - $urandom_range(0, 31);
          add_beat(OP_RECORD, bd, code);
        end
      end else if (pick <= 6) begin
        len = $urandom_range(8, 40);
        for (int i = 0; i < len; i++)
          add_beat(OP_READ, bd, CODE_TOP - i);
      end else if (pick == 7) begin
        code = $urandom_range(20, BIN_DEPTH - 1);
        len  = $urandom_range(5, 20);
        for (int i = 0; i < len; i++)
          add_beat(OP_READ, bd, code - i);
      end else if (pick == 8) begin
        repeat (5)
          add_beat(1'($urandom_range(0, 1)), $urandom_range(0, NUM_BOARDS_DEF - 1),
                   $urandom_range(0, BIN_DEPTH - 1));
      end else begin
        code = $urandom_range(0, BIN_DEPTH - 1);
        len  = $urandom_range(4, 10);
        repeat (len) add_beat(OP_RECORD, bd, code);
        add_beat(OP_READ, bd, code);
      end
    end
  end

  // driver
  always @(posedge clk) begin : drive_in
    bit idle_ok;
    idle_ok = (stim_beats.size() > 200) && (((beats_taken / 150) % 3) != 2);
    idle_phase <= idle_ok;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        histogram_update(in_item);
        beats_taken <= beats_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (stim_beats.size() != 0) begin
          if (idle_ok && $urandom_range(0, 7) == 0) begin
            gap_left <= $urandom_range(0, 6);
            in_valid <= 1'b0;
          end else begin
            in_valid <= 1'b1;
            in_item  <= stim_beats.pop_front();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and result-side flow control
  always @(posedge clk) begin : watch_out
    out_item_t want;
    bit        took;
    took = out_valid && out_ready;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (took) begin
        results_seen++;
        if (expected_bins.size() == 0) begin
          $display("%0t: unexpected result beat, actual %h", $time, out_item);
          mismatches++;
        end else begin
          want = expected_bins.pop_front();
          if (out_item.bin_count !== want.bin_count) begin
            $display("%0t: bin_count expected %0d actual %0d", $time,
                     want.bin_count, out_item.bin_count);
            mismatches++;
          end
          if (out_item.was_filled !== want.was_filled) begin
            $display("%0t: was_filled expected %0b actual %0b", $time,
                     want.was_filled, out_item.was_filled);
            mismatches++;
          end
          if (out_item.board_used !== want.board_used) begin
            $display("%0t: board_used expected %0b actual %0b", $time,
                     want.board_used, out_item.board_used);
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (took && (results_seen == 150 || results_seen == 900)) begin
        // long hold-off so the input side backs up
        hold_left = 120;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_phase && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats still expected", $time, expected_bins.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    @(posedge rst_n);
    do @(negedge clk);
    while (stim_beats.size() != 0 || in_valid || expected_bins.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_bins.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, expected_bins.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
sv/pbah_pkg.sv
sv/pbah_front.sv
sv/pbah_engine.sv
sv/per_board_adc_histogram.sv
test/per_board_adc_histogram_test.sv
